FILE: hdl/gne_pkg.sv
// Gradient noise evaluator package: beat types and gradient selection.
// Used by the evaluator top level and the testbench; no dependencies.
package gne_pkg;

   typedef struct packed {
      logic              func;
      logic [7:0]        perm_index;
      logic [7:0]        perm_value;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic signed [31:0] coord_w;
   } gne_req_type;

   typedef struct packed {
      logic              is_noise;
      logic signed [23:0] noise_value;
   } gne_rsp_type;

   localparam logic       FUNC_LOAD     = 1'b0;
   localparam logic       FUNC_EVAL     = 1'b1;
   localparam logic [2:0] DIM_RESET     = 3'd3;
   localparam int         MAX_DIMS      = 4;
   localparam int         MAX_CORNERS   = 16;
   localparam int         OUT_WIDTH     = 24;

   // gradient component codes, two bits per dimension
   localparam logic [1:0] GP = 2'b01;
   localparam logic [1:0] GM = 2'b11;
   localparam logic [1:0] GZ = 2'b00;

   localparam logic [5:0] GRAD3 [16] = '{
      {GZ, GP, GP}, {GZ, GP, GM}, {GZ, GM, GP}, {GZ, GM, GM},
      {GP, GZ, GP}, {GP, GZ, GM}, {GM, GZ, GP}, {GM, GZ, GM},
      {GP, GP, GZ}, {GP, GM, GZ}, {GM, GP, GZ}, {GM, GM, GZ},
      {GZ, GP, GP}, {GZ, GP, GM}, {GP, GM, GZ}, {GM, GM, GZ}
   };

   function automatic logic [1:0] sgn_code(input logic neg);
      return neg ? GM : GP;
   endfunction

   // nsel is dimension count minus one; result holds {w, z, y, x} codes
   function automatic logic [7:0] grad_code(input logic [1:0] nsel, input logic [7:0] h);
      logic [7:0] g;
      g = '0;
      case (nsel)
         2'd0: begin
            g = {GZ, GZ, GZ, sgn_code(h[0])};
         end
         2'd1: begin
            case (h[1:0])
               2'd0:    g = {GZ, GZ, GZ, GP};
               2'd1:    g = {GZ, GZ, GZ, GM};
               2'd2:    g = {GZ, GZ, GP, GZ};
               default: g = {GZ, GZ, GM, GZ};
            endcase
         end
         2'd2: begin
            g = {GZ, GRAD3[h[3:0]]};
         end
         default: begin
            case (h[4:3])
               2'd0:    g = {GZ, sgn_code(h[2]), sgn_code(h[1]), sgn_code(h[0])};
               2'd1:    g = {sgn_code(h[2]), GZ, sgn_code(h[1]), sgn_code(h[0])};
               2'd2:    g = {sgn_code(h[2]), sgn_code(h[1]), GZ, sgn_code(h[0])};
               default: g = {sgn_code(h[2]), sgn_code(h[1]), sgn_code(h[0]), GZ};
            endcase
         end
      endcase
      return g;
   endfunction

endpackage

FILE: hdl/gne_qmul_unit.sv
// Shared fixed-point multiply-accumulate: (a*b rounded half up) + addend.
// Depends on nothing; used by the evaluator sequencer.
module gne_qmul_unit #(
   parameter int W = 22,
   parameter int F = 16
) (
   input  logic signed [W-1:0] opa,
   input  logic signed [W-1:0] opb,
   input  logic signed [W-1:0] addend,
   output logic signed [W-1:0] result
);
   localparam logic signed [2*W-1:0] HALF = (2*W)'(1) <<< (F - 1);

   logic signed [2*W-1:0] prod;
   logic signed [2*W-1:0] shifted;

   assign prod    = (2*W)'(opa) * (2*W)'(opb) + HALF;
   assign shifted = prod >>> F;
   assign result  = signed'(shifted[W-1:0]) + addend;
endmodule

FILE: hdl/gne_perm_ram.sv
// Permutation table memory: one write port, one registered read port.
// Depends on nothing; used by the evaluator top level.
module gne_perm_ram #(
   parameter int ENTRIES = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [7:0]                 rd_data
);
   logic [7:0] mem [ENTRIES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/gradient_noise_evaluator.sv
// Gradient noise evaluator top level: sequencer, queue, output register.
// Uses gne_pkg, gne_qmul_unit and gne_perm_ram.
// A load beat is acknowledged from S_ACK; an evaluate beat steps through fade, hash,
// gradient and blend states, paced by the one shared multiplier and table read port.
// No new beat is taken before the last is done; rsp_stall can hold the sequencer too.
// Reset (synchronous): dimension count 3, sequencer idle; table not cleared.
module gradient_noise_evaluator #(
   parameter int PERM_ENTRIES = 256,
   parameter int FRAC_BITS    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gne_pkg::gne_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output gne_pkg::gne_rsp_type rsp_payload,
   input  logic                 csr_write_enable,
   input  logic [2:0]           csr_write_data
);
   import gne_pkg::*;

   localparam int AW = $clog2(PERM_ENTRIES);
   localparam int F  = FRAC_BITS;
   localparam int W  = F + 6;
   localparam logic signed [W-1:0] FIFTEEN = W'(15) <<< F;
   localparam logic signed [W-1:0] TEN     = W'(10) <<< F;
   localparam logic signed [31:0] SAT_MAX = 32'sd8388607;
   localparam logic signed [31:0] SAT_MIN = -32'sd8388608;

   typedef enum logic [2:0] {
      S_IDLE, S_ACK, S_FADE_INIT, S_FADE, S_HASH_RD, S_HASH_WT, S_GRAD, S_BLEND
   } state_type;

   state_type          state_ff;
   logic [2:0]         dim_ff;
   logic [1:0]         nsel_ff;
   logic [1:0]         d_ff;
   logic [1:0]         step_ff;
   logic [3:0]         c_ff;
   logic [7:0]         h_ff;
   logic [4:0]         qcnt_ff;
   logic [3:0]         pairs_ff;
   logic [3:0]         level_pairs_ff;
   logic [AW-1:0]      lat_ff   [MAX_DIMS];
   logic [F-1:0]       frac_ff  [MAX_DIMS];
   logic signed [W-1:0] u_ff    [MAX_DIMS];
   logic signed [W-1:0] acc_ff;
   logic signed [W-1:0] q_ff    [MAX_CORNERS];
   logic               rsp_valid_ff;
   gne_rsp_type        rsp_payload_ff;

   logic               accept;
   logic               rsp_free;
   logic               rsp_load;
   logic [1:0]         nsel_in;
   logic signed [31:0] coord [MAX_DIMS];
   logic signed [W-1:0] mul_a, mul_b, mul_add, mul_res;
   logic [AW-1:0]      rd_addr;
   logic [7:0]         rd_data;
   logic [7:0]         gcode;
   logic signed [W-1:0] grad_sum;
   logic [3:0]         corner_last;
   logic signed [31:0] final_ext;
   logic signed [23:0] final_sat;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = rsp_free && ((state_ff == S_ACK) ||
                                  (state_ff == S_BLEND && level_pairs_ff == 4'd0));
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign coord[0] = req_payload.coord_x;
   assign coord[1] = req_payload.coord_y;
   assign coord[2] = req_payload.coord_z;
   assign coord[3] = req_payload.coord_w;

   always_comb begin
      if (dim_ff == 3'd0) begin
         nsel_in = 2'd0;
      end else if (dim_ff >= 3'd4) begin
         nsel_in = 2'd3;
      end else begin
         nsel_in = 2'(dim_ff - 3'd1);
      end
   end

   always_comb begin
      case (state_ff)
         S_FADE: begin
            mul_a   = acc_ff;
            mul_b   = signed'(W'(frac_ff[d_ff]));
            mul_add = (step_ff == 2'd0) ? TEN : '0;
         end
         default: begin
            mul_a   = u_ff[d_ff];
            mul_b   = q_ff[1] - q_ff[0];
            mul_add = q_ff[0];
         end
      endcase
   end

   gne_qmul_unit #(.W(W), .F(F)) u_qmul (
      .opa    (mul_a),
      .opb    (mul_b),
      .addend (mul_add),
      .result (mul_res)
   );

   assign rd_addr = AW'(h_ff) + lat_ff[d_ff] + AW'(c_ff[d_ff]);

   gne_perm_ram #(.ENTRIES(PERM_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (accept && (req_payload.func == FUNC_LOAD)),
      .wr_addr (AW'(req_payload.perm_index)),
      .wr_data (req_payload.perm_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign gcode = grad_code(nsel_ff, h_ff);

   always_comb begin
      grad_sum = '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
         case (gcode[2*i +: 2])
            GP:      grad_sum = grad_sum + W'(signed'({c_ff[i], frac_ff[i]}));
            GM:      grad_sum = grad_sum - W'(signed'({c_ff[i], frac_ff[i]}));
            default: grad_sum = grad_sum;
         endcase
      end
   end

   assign corner_last = 4'((5'd1 << (3'(nsel_ff) + 3'd1)) - 5'd1);

   assign final_ext = 32'(q_ff[0]);
   always_comb begin
      if (final_ext > SAT_MAX) begin
         final_sat = SAT_MAX[23:0];
      end else if (final_ext < SAT_MIN) begin
         final_sat = SAT_MIN[23:0];
      end else begin
         final_sat = final_ext[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dim_ff       <= DIM_RESET;
         rsp_valid_ff <= 1'b0;
         qcnt_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            dim_ff <= csr_write_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_payload.func == FUNC_LOAD) begin
                     state_ff <= S_ACK;
                  end else begin
                     for (int i = 0; i < MAX_DIMS; i++) begin
                        lat_ff[i]  <= AW'(64'(coord[i]) >> F);
                        frac_ff[i] <= coord[i][F-1:0];
                     end
                     nsel_ff  <= nsel_in;
                     d_ff     <= '0;
                     state_ff <= S_FADE_INIT;
                  end
               end
            end
            S_ACK: begin
               if (rsp_free) begin
                  rsp_payload_ff.is_noise     <= 1'b0;
                  rsp_payload_ff.noise_value  <= '0;
                  state_ff                    <= S_IDLE;
               end
            end
            S_FADE_INIT: begin
               acc_ff   <= (W'(frac_ff[d_ff]) << 2) + (W'(frac_ff[d_ff]) << 1) - FIFTEEN;
               step_ff  <= '0;
               state_ff <= S_FADE;
            end
            S_FADE: begin
               acc_ff <= mul_res;
               if (step_ff == 2'd3) begin
                  u_ff[d_ff] <= mul_res;
                  if (d_ff == nsel_ff) begin
                     d_ff     <= '0;
                     c_ff     <= '0;
                     h_ff     <= '0;
                     qcnt_ff  <= '0;
                     state_ff <= S_HASH_RD;
                  end else begin
                     d_ff     <= d_ff + 2'd1;
                     state_ff <= S_FADE_INIT;
                  end
               end else begin
                  step_ff <= step_ff + 2'd1;
               end
            end
            S_HASH_RD: begin
               state_ff <= S_HASH_WT;
            end
            S_HASH_WT: begin
               h_ff <= rd_data;
               if (d_ff == nsel_ff) begin
                  state_ff <= S_GRAD;
               end else begin
                  d_ff     <= d_ff + 2'd1;
                  state_ff <= S_HASH_RD;
               end
            end
            S_GRAD: begin
               q_ff[qcnt_ff[3:0]] <= grad_sum;
               qcnt_ff            <= qcnt_ff + 5'd1;
               d_ff               <= '0;
               h_ff               <= '0;
               if (c_ff == corner_last) begin
                  pairs_ff       <= 4'(5'd1 << nsel_ff);
                  level_pairs_ff <= 4'(5'd1 << nsel_ff);
                  state_ff       <= S_BLEND;
               end else begin
                  c_ff     <= c_ff + 4'd1;
                  state_ff <= S_HASH_RD;
               end
            end
            S_BLEND: begin
               if (level_pairs_ff == 4'd0) begin
                  if (rsp_free) begin
                     rsp_payload_ff.is_noise    <= 1'b1;
                     rsp_payload_ff.noise_value <= final_sat;
                     state_ff                   <= S_IDLE;
                  end
               end else begin
                  for (int i = 0; i < MAX_CORNERS - 2; i++) begin
                     if (5'(i) != qcnt_ff - 5'd2) begin
                        q_ff[i] <= q_ff[i+2];
                     end
                  end
                  q_ff[4'(qcnt_ff - 5'd2)] <= mul_res;
                  qcnt_ff <= qcnt_ff - 5'd1;
                  if (pairs_ff == 4'd1) begin
                     level_pairs_ff <= level_pairs_ff >> 1;
                     pairs_ff       <= level_pairs_ff >> 1;
                     d_ff           <= d_ff + 2'd1;
                  end else begin
                     pairs_ff <= pairs_ff - 4'd1;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_qcnt_bound: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= 5'(MAX_CORNERS))
      else $error("queue count overflow");
   a_blend_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BLEND && level_pairs_ff != 4'd0) |-> qcnt_ff >= 5'd2)
      else $error("blend with fewer than two queued values");
   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.is_noise) |-> rsp_payload.noise_value == '0)
      else $error("load acknowledge carries nonzero value");
   a_load_ack: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.func == FUNC_LOAD) |=> state_ff == S_ACK)
      else $error("load beat not acknowledged");
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BLEND && level_pairs_ff == 4'd0) |-> qcnt_ff == 5'd1)
      else $error("blend finished with wrong queue depth");
`endif
endmodule

FILE: verif/tb_gradient_noise_evaluator.sv
// Testbench for gradient_noise_evaluator: table loads, noise evaluation in 1 to 4 dims.
// Self-checking with a noise predictor in a scoreboard class; depends on gne_pkg and the RTL.
module tb_gradient_noise_evaluator;
   import gne_pkg::*;

   localparam int FRAC = 16;
   localparam longint ONE = 64'sd1 << FRAC;

   class noise_scoreboard;
      logic [7:0] perm [256];
      int dims;
      gne_rsp_type pending[$];
      int errors;

      function new();
         dims = DIM_RESET;
         errors = 0;
         foreach (perm[i]) perm[i] = 8'd0;
      endfunction

      function longint rmul(longint a, longint b);
         longint p;
         p = a * b + (ONE >>> 1);
         return p >>> FRAC;
      endfunction

      function longint fade(longint f);
         longint v;
         v = 6 * f - 15 * ONE;
         v = rmul(v, f) + 10 * ONE;
         v = rmul(v, f);
         v = rmul(v, f);
         return rmul(v, f);
      endfunction

      // gradient component for dimension d, from the package-independent tables
      function int grad_comp(int n, logic [7:0] h, int d);
         int g3 [16][3];
         int hb;
         g3 = '{'{1,1,0}, '{-1,1,0}, '{1,-1,0}, '{-1,-1,0},
                '{1,0,1}, '{-1,0,1}, '{1,0,-1}, '{-1,0,-1},
                '{0,1,1}, '{0,-1,1}, '{0,1,-1}, '{0,-1,-1},
                '{1,1,0}, '{-1,1,0}, '{0,-1,1}, '{0,-1,-1}};
         if (n == 1) return h[0] ? -1 : 1;
         if (n == 2) begin
            case (h[1:0])
               2'd0: return d == 0 ? 1 : 0;
               2'd1: return d == 0 ? -1 : 0;
               2'd2: return d == 1 ? 1 : 0;
               default: return d == 1 ? -1 : 0;
            endcase
         end
         if (n == 3) return g3[h[3:0]][d];
         // 4D: zero slot chosen by h[4:3], remaining dims take signs h[0], h[1], h[2]
         hb = int'(h[4:3]);
         if (d == 3 - hb) return 0;
         if (d < 3 - hb) return h[d] ? -1 : 1;
         return h[d - 1] ? -1 : 1;
      endfunction

      function void note_request(gne_req_type r);
         gne_rsp_type e;
         logic signed [31:0] cs [4];
         logic [7:0] lat [4];
         longint rel [4], u [4], val [16], g, a, b, res;
         logic [7:0] h;
         int n, bitc;
         e = '0;
         if (r.func == FUNC_LOAD) begin
            perm[r.perm_index] = r.perm_value;
         end else begin
            n = dims < 1 ? 1 : (dims > 4 ? 4 : dims);
            cs = '{r.coord_x, r.coord_y, r.coord_z, r.coord_w};
            for (int d = 0; d < n; d++) begin
               rel[d] = longint'(cs[d][FRAC-1:0]);
               lat[d] = cs[d][FRAC+7:FRAC];
               u[d] = fade(rel[d]);
            end
            for (int c = 0; c < (1 << n); c++) begin
               h = '0;
               g = 0;
               for (int d = 0; d < n; d++) begin
                  bitc = (c >> d) & 1;
                  h = perm[8'(h + lat[d] + bitc)];
               end
               for (int d = 0; d < n; d++) begin
                  bitc = (c >> d) & 1;
                  g += grad_comp(n, h, d) * (bitc ? rel[d] - ONE : rel[d]);
               end
               val[c] = g;
            end
            for (int d = 0; d < n; d++)
               for (int k = 0; k < (1 << (n - 1 - d)); k++) begin
                  a = val[2*k];
                  b = val[2*k+1];
                  val[k] = a + rmul(u[d], b - a);
               end
            res = val[0];
            if (res > 8388607) res = 8388607;
            if (res < -8388608) res = -8388608;
            e.is_noise = 1'b1;
            e.noise_value = res[23:0];
         end
         pending.push_back(e);
      endfunction

      function void check_result(gne_rsp_type got);
         gne_rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result beat %h", got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.is_noise !== e.is_noise) begin
            $error("is_noise expected %0d actual %0d", e.is_noise, got.is_noise);
            errors++;
         end
         if (got.noise_value !== e.noise_value) begin
            $error("noise_value expected %0d actual %0d", e.noise_value, got.noise_value);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   gne_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   gne_rsp_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_write_data = '0;

   noise_scoreboard sb = new();
   bit quiet = 1'b0;
   bit hold_long = 1'b0;

   always #1 clock = ~clock;

   gradient_noise_evaluator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_payload);
   end

   // receiver stalls: random bursts, one long hold-off on request
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
            hold_long = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   task automatic send_beat(gne_req_type r);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_dims(logic [2:0] d);
      csr_write_enable <= 1'b1;
      csr_write_data <= d;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.dims = d;
   endtask

   task automatic load_entry(logic [7:0] idx, logic [7:0] val);
      gne_req_type r;
      r = '0;
      r.func = FUNC_LOAD;
      r.perm_index = idx;
      r.perm_value = val;
      r.coord_x = $urandom();
      r.coord_w = $urandom();
      send_beat(r);
   endtask

   function automatic logic signed [31:0] rand_coord(int mode);
      logic signed [31:0] v;
      case (mode)
         0: v = $urandom();
         1: v = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
         2: v = $urandom_range(0, 3) == 0 ? 32'h7FFFFFFF : 32'sh80000000;
         default: v = {16'($urandom()), $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF};
      endcase
      return v;
   endfunction

   task automatic eval_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic signed [31:0] w);
      gne_req_type r;
      r = '0;
      r.func = FUNC_EVAL;
      r.perm_index = 8'($urandom());
      r.perm_value = 8'($urandom());
      r.coord_x = x;
      r.coord_y = y;
      r.coord_z = z;
      r.coord_w = w;
      send_beat(r);
   endtask

   task automatic eval_random();
      int m;
      m = $urandom_range(0, 5);
      eval_point(rand_coord(m % 4), rand_coord(m % 4), rand_coord($urandom_range(0, 3)),
                 rand_coord($urandom_range(0, 3)));
   endtask

   initial begin
      logic [7:0] shuf [256];
      int tmp, j;
      logic [2:0] dim_list [8];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full table, some extremes at reset dims
      for (int i = 0; i < 256; i++) load_entry(8'(i), 8'(255 - i));
      eval_point(32'sh0, 32'sh0, 32'sh0, 32'sh0);
      eval_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      eval_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
      eval_point(32'h0000FFFF, 32'hFFFF0001, 32'h00008000, 32'hFFFFFFFF);
      eval_point(32'h00018000, 32'hFFFF8000, 32'h7FFF0000, 32'h80000001);

      dim_list = '{3'd1, 3'd2, 3'd4, 3'd0, 3'd7, 3'd5, 3'd6, 3'd3};
      for (int p = 0; p < 8; p++) begin
         go_idle();
         set_dims(dim_list[p]);
         if (p == 2) begin
            foreach (shuf[i]) shuf[i] = 8'(i);
            for (int i = 255; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = shuf[i]; shuf[i] = shuf[j]; shuf[j] = 8'(tmp);
            end
            for (int i = 0; i < 256; i++) load_entry(8'(i), shuf[i]);
         end
         eval_point(32'sh80000000, 32'h7FFFFFFF, 32'h0000FFFF, 32'hFFFF0000);
         eval_point(32'h7FFFFFFF, 32'sh80000000, 32'hFFFFFFFF, 32'h00010000);
         if (p == 1) hold_long = 1'b1;
         // reloads of single entries with random values keep the table fully written
         for (int i = 0; i < 110; i++) begin
            if (i == 90 && p == 7) quiet = 1'b1;
            if ($urandom_range(0, 9) == 0) load_entry(8'($urandom()), 8'($urandom()));
            else eval_random();
         end
      end
      go_idle();
      if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #3000000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
